[sv/vtc_pkg.sv]
// shared types and constants of the virtual timestamp counter
package vtc_pkg;

    // input word kinds
    typedef enum logic [2:0] {
        KIND_START      = 3'd0,
        KIND_ADVANCE    = 3'd1,
        KIND_READ_CNT   = 3'd2,
        KIND_WRITE_CNT  = 3'd3,
        KIND_READ_AUX   = 3'd4,
        KIND_WRITE_AUX  = 3'd5,
        KIND_TIMER_UPD  = 3'd6,
        KIND_CNT_AUX    = 3'd7
    } kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FOLLOW_HOST = 3'd0,
        REG_DIL_NUM     = 3'd1,
        REG_DIL_DENOM   = 3'd2,
        REG_CLK_NUM     = 3'd3,
        REG_CLK_DENOM   = 3'd4
    } reg_idx_t;

    localparam int unsigned PADDR_W = 5;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_UDIV = 2'd1,
        OP_SDIV = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // arithmetic unit sequencer
    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL_LO,
        A_MUL_HI,
        A_MUL_SUM,
        A_DIV,
        A_DIV_FIX
    } arith_state_t;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_RESULT
    } seq_state_t;

endpackage

[sv/vtc_arith.sv]
// shared multiply and bit-serial divide unit (64 by 32 bits)
module vtc_arith (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vtc_pkg::arith_req_t  req,
    input  logic [63:0]          op_a,
    input  logic [31:0]          op_b,
    output logic                 done,
    output logic [63:0]          result
);

    vtc_pkg::arith_state_t state_reg, state_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] b_reg, b_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] hi_reg, hi_next;
    logic [63:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic        ge;

    // single 32x32 multiplier, operand half chosen by state
    assign mul_a = (state_reg == vtc_pkg::A_MUL_LO) ? quo_reg[31:0] : quo_reg[63:32];
    assign mul_p = 64'(mul_a) * 64'(b_reg);

    // restoring divide step
    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_sub = trial - {1'b0, b_reg};
    assign ge        = (trial >= {1'b0, b_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vtc_pkg::A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        b_reg    <= b_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        hi_reg   <= hi_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        hi_next    = hi_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            vtc_pkg::A_IDLE: begin
                if (req.start) begin
                    b_next   = op_b;
                    rem_next = '0;
                    cnt_next = '0;
                    neg_next = (req.op == vtc_pkg::OP_SDIV) && op_a[63];
                    // divide works on the magnitude of a signed dividend
                    quo_next = ((req.op == vtc_pkg::OP_SDIV) && op_a[63]) ? (64'd0 - op_a)
                                                                         : op_a;
                    state_next = (req.op == vtc_pkg::OP_MUL) ? vtc_pkg::A_MUL_LO
                                                             : vtc_pkg::A_DIV;
                end
            end
            vtc_pkg::A_MUL_LO: begin
                prod_next  = mul_p;
                state_next = vtc_pkg::A_MUL_HI;
            end
            vtc_pkg::A_MUL_HI: begin
                hi_next    = mul_p[31:0];
                state_next = vtc_pkg::A_MUL_SUM;
            end
            vtc_pkg::A_MUL_SUM: begin
                // product wraps at 64 bits
                res_next   = prod_reg + {hi_reg, 32'd0};
                done_next  = 1'b1;
                state_next = vtc_pkg::A_IDLE;
            end
            vtc_pkg::A_DIV: begin
                rem_next = ge ? trial_sub[31:0] : trial[31:0];
                quo_next = {quo_reg[62:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = vtc_pkg::A_DIV_FIX;
                end
            end
            vtc_pkg::A_DIV_FIX: begin
                // zero divisor gives all ones, else restore the sign
                if (b_reg == 32'd0) begin
                    res_next = '1;
                end else if (neg_reg) begin
                    res_next = 64'd0 - quo_reg;
                end else begin
                    res_next = quo_reg;
                end
                done_next  = 1'b1;
                state_next = vtc_pkg::A_IDLE;
            end
            default: begin
                state_next = vtc_pkg::A_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/virtual_timestamp_counter_top.sv]
// virtual timestamp counter: registers, sequencer and result register
//
//  channel   direction  ports                                          handshake
//  s_        in         s_kind, s_value                                s_valid / s_ready
//  m_        out        m_read_value, m_aux_low, m_rolled_over         m_valid / m_ready
//  apb       in/out     psel, penable, pwrite, paddr, pwdata, prdata   pready (always high)
//
// one word at a time; reads, writes, start and timer update go through the result state to the
// output register. advance runs through the shared multiply/divide unit: two multiplies and two
// 64-step divides when following host time, one multiply and one divide when adding cycles.
// s_ready is high only while the sequencer is idle; a finished word waits in the
// output register while the next word is taken in. reset is synchronous, active low.
module virtual_timestamp_counter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic [63:0]                   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [63:0]                   m_read_value,
    output logic [31:0]                   m_aux_low,
    output logic                          m_rolled_over,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vtc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration registers
    logic        follow_reg;
    logic [31:0] dil_num_reg;
    logic [31:0] dil_denom_reg;
    logic [31:0] clk_num_reg;
    logic [31:0] clk_denom_reg;

    // guest state
    logic [63:0] guest_time_reg, guest_time_next;
    logic [63:0] offset_reg, offset_next;
    logic [63:0] mark_reg, mark_next;
    logic [63:0] base_reg, base_next;
    logic [63:0] aux_reg, aux_next;

    // pending result and output register
    logic [63:0] res_value_reg, res_value_next;
    logic [31:0] res_aux_reg, res_aux_next;
    logic        res_ro_reg, res_ro_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_value_reg, m_value_next;
    logic [31:0] m_aux_reg, m_aux_next;
    logic        m_ro_reg, m_ro_next;

    vtc_pkg::seq_state_t state_reg, state_next;

    vtc_pkg::arith_req_t arith_req;
    logic [63:0]         arith_a;
    logic [31:0]         arith_b;
    logic                arith_done;
    logic [63:0]         arith_res;

    logic                apb_wr;
    vtc_pkg::reg_idx_t   reg_idx;
    logic [63:0]         diff;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = vtc_pkg::reg_idx_t'(paddr[vtc_pkg::PADDR_W-1:2]);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_reg    <= 1'b1;
            dil_num_reg   <= 32'd1;
            dil_denom_reg <= 32'd1;
            clk_num_reg   <= 32'd1;
            clk_denom_reg <= 32'd1;
        end else if (apb_wr) begin
            unique case (reg_idx)
                vtc_pkg::REG_FOLLOW_HOST: follow_reg    <= pwdata[0];
                vtc_pkg::REG_DIL_NUM:     dil_num_reg   <= pwdata;
                vtc_pkg::REG_DIL_DENOM:   dil_denom_reg <= pwdata;
                vtc_pkg::REG_CLK_NUM:     clk_num_reg   <= pwdata;
                vtc_pkg::REG_CLK_DENOM:   clk_denom_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (reg_idx)
            vtc_pkg::REG_FOLLOW_HOST: prdata = {31'd0, follow_reg};
            vtc_pkg::REG_DIL_NUM:     prdata = dil_num_reg;
            vtc_pkg::REG_DIL_DENOM:   prdata = dil_denom_reg;
            vtc_pkg::REG_CLK_NUM:     prdata = clk_num_reg;
            vtc_pkg::REG_CLK_DENOM:   prdata = clk_denom_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    vtc_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .op_a    (arith_a),
        .op_b    (arith_b),
        .done    (arith_done),
        .result  (arith_res)
    );

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= vtc_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            guest_time_reg <= '0;
            offset_reg     <= '0;
            mark_reg       <= '0;
            base_reg       <= '0;
            aux_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            guest_time_reg <= guest_time_next;
            offset_reg     <= offset_next;
            mark_reg       <= mark_next;
            base_reg       <= base_next;
            aux_reg        <= aux_next;
        end
        res_value_reg <= res_value_next;
        res_aux_reg   <= res_aux_next;
        res_ro_reg    <= res_ro_next;
        m_value_reg   <= m_value_next;
        m_aux_reg     <= m_aux_next;
        m_ro_reg      <= m_ro_next;
    end

    assign diff = guest_time_reg - mark_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        guest_time_next = guest_time_reg;
        offset_next     = offset_reg;
        mark_next       = mark_reg;
        base_next       = base_reg;
        aux_next        = aux_reg;
        res_value_next  = res_value_reg;
        res_aux_next    = res_aux_reg;
        res_ro_next     = res_ro_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_aux_next      = m_aux_reg;
        m_ro_next       = m_ro_reg;
        arith_req.start = 1'b0;
        arith_req.op    = vtc_pkg::OP_MUL;
        arith_a         = arith_res;
        arith_b         = clk_num_reg;
        s_ready         = 1'b0;
        unique case (state_reg)
            vtc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_value_next = '0;
                    res_aux_next   = '0;
                    res_ro_next    = 1'b0;
                    state_next     = vtc_pkg::ST_RESULT;
                    unique case (vtc_pkg::kind_t'(s_kind))
                        vtc_pkg::KIND_START: begin
                            base_next       = s_value;
                            mark_next       = '0;
                            guest_time_next = '0;
                        end
                        vtc_pkg::KIND_ADVANCE: begin
                            // first multiply: dilation in follow mode, clock ratio otherwise
                            arith_req.start = 1'b1;
                            arith_req.op    = vtc_pkg::OP_MUL;
                            if (follow_reg) begin
                                arith_a    = s_value - base_reg;
                                arith_b    = dil_num_reg;
                                state_next = vtc_pkg::ST_MUL1;
                            end else begin
                                arith_a    = s_value;
                                arith_b    = clk_num_reg;
                                state_next = vtc_pkg::ST_MUL2;
                            end
                        end
                        vtc_pkg::KIND_READ_CNT: begin
                            res_value_next = guest_time_reg + offset_reg;
                        end
                        vtc_pkg::KIND_WRITE_CNT: begin
                            offset_next = s_value - guest_time_reg;
                        end
                        vtc_pkg::KIND_READ_AUX: begin
                            res_value_next = aux_reg;
                        end
                        vtc_pkg::KIND_WRITE_AUX: begin
                            aux_next = s_value;
                        end
                        vtc_pkg::KIND_TIMER_UPD: begin
                            // mark moves even on rollover
                            mark_next      = guest_time_reg;
                            res_ro_next    = diff[63];
                            res_value_next = diff[63] ? 64'd0 : diff;
                        end
                        vtc_pkg::KIND_CNT_AUX: begin
                            res_value_next = guest_time_reg + offset_reg;
                            res_aux_next   = aux_reg[31:0];
                        end
                        default: ;
                    endcase
                end
            end
            vtc_pkg::ST_MUL1: begin
                if (arith_done) begin
                    arith_req.start = 1'b1;
                    arith_req.op    = vtc_pkg::OP_UDIV;
                    arith_b         = dil_denom_reg;
                    state_next      = vtc_pkg::ST_DIV1;
                end
            end
            vtc_pkg::ST_DIV1: begin
                if (arith_done) begin
                    arith_req.start = 1'b1;
                    arith_req.op    = vtc_pkg::OP_MUL;
                    arith_b         = clk_num_reg;
                    state_next      = vtc_pkg::ST_MUL2;
                end
            end
            vtc_pkg::ST_MUL2: begin
                if (arith_done) begin
                    arith_req.start = 1'b1;
                    arith_req.op    = vtc_pkg::OP_SDIV;
                    arith_b         = clk_denom_reg;
                    state_next      = vtc_pkg::ST_DIV2;
                end
            end
            vtc_pkg::ST_DIV2: begin
                // scaled value replaces or adds to guest time
                if (arith_done) begin
                    guest_time_next = follow_reg ? arith_res : guest_time_reg + arith_res;
                    state_next      = vtc_pkg::ST_RESULT;
                end
            end
            vtc_pkg::ST_RESULT: begin
                // hand the word to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_aux_next   = res_aux_reg;
                    m_ro_next    = res_ro_reg;
                    state_next   = vtc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vtc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_aux_low     = m_aux_reg;
    assign m_rolled_over = m_ro_reg;

endmodule
